[rtl/core/icr_pkg.sv]
// ----------------------------------------------------------------------------
// icr_pkg
// Shared constants for the interrupt controller register core: action codes,
// register offsets, field widths and the implemented line mask.
// ----------------------------------------------------------------------------
package icr_pkg;

	localparam int NUM_LINES = 16;

	localparam int LINE_W   = 16;
	localparam int WAIT_W   = 15;
	localparam int DATA_W   = 32;
	localparam int OFS_W    = 8;
	localparam int SIZE_W   = 3;
	localparam int ACTION_W = 2;
	localparam int INDEX_W  = 4;

	localparam logic [ACTION_W-1:0] ACT_LINE  = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_READ  = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_WRITE = 2'd2;

	localparam logic [OFS_W-1:0] OFS_ENABLE  = 8'h00;
	localparam logic [OFS_W-1:0] OFS_PENDING = 8'h02;
	localparam logic [OFS_W-1:0] OFS_WAIT    = 8'h04;
	localparam logic [OFS_W-1:0] OFS_MASTER  = 8'h08;

	localparam logic [SIZE_W-1:0] SIZE_HALF = 3'd2;
	localparam logic [SIZE_W-1:0] SIZE_WORD = 3'd4;

	localparam logic [LINE_W-1:0] LINE_MASK =
		LINE_W'((33'd1 << NUM_LINES) - 33'd1);

endpackage

[rtl/core/interrupt_controller_regs_core.sv]
// ----------------------------------------------------------------------------
// interrupt_controller_regs_core
// Sixteen-line interrupt controller behind a small register window. Each input
// word is a line level change, a register read or a register write; each one
// returns exactly one result word carrying the read data, the interrupt
// request after that word and an access error flag. Registers: enable mask
// (offset 0, a 32-bit access also covers the pending flags), pending flags
// (offset 2, write ones to clear), wait control (offset 4, 15 bits) and master
// enable (offset 8, bit 0 set enables). Unknown offsets read zero, ignore
// writes and flag an error; oversize accesses flag an error but still take
// effect. One word is accepted every cycle while the result side keeps up; a
// result appears at the edge that moves the word from the input register into
// the result register, and the register state is updated at that same edge.
// While the result side stalls, the core holds one word in its input register
// and one in its result register, then stalls its input.
// ----------------------------------------------------------------------------
module interrupt_controller_regs_core
	import icr_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [ACTION_W-1:0] action,
	input  logic [INDEX_W-1:0]  line_index,
	input  logic                line_level,
	input  logic [OFS_W-1:0]    reg_offset,
	input  logic [SIZE_W-1:0]   access_size,
	input  logic [DATA_W-1:0]   write_data,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [DATA_W-1:0]   read_data,
	output logic                irq_out,
	output logic                access_error
);

	logic                valid_s1;
	logic [ACTION_W-1:0] action_s1;
	logic [INDEX_W-1:0]  index_s1;
	logic                level_s1;
	logic [OFS_W-1:0]    ofs_s1;
	logic [SIZE_W-1:0]   size_s1;
	logic [DATA_W-1:0]   data_s1;

	logic [LINE_W-1:0]   pending_q;
	logic [LINE_W-1:0]   enable_q;
	logic [WAIT_W-1:0]   wait_q;
	logic                master_q;

	logic                out_valid_q;
	logic [DATA_W-1:0]   read_data_q;
	logic                irq_q;
	logic                error_q;

	logic                out_free;
	logic                advance;
	logic                in_take;

	logic [LINE_W-1:0]   pending_nxt;
	logic [LINE_W-1:0]   enable_nxt;
	logic [WAIT_W-1:0]   wait_nxt;
	logic                master_nxt;
	logic [DATA_W-1:0]   rdata_nxt;
	logic                error_nxt;
	logic                irq_nxt;
	logic [LINE_W-1:0]   line_bit;
	logic                index_ok;
	logic                size_over_word;
	logic                size_over_half;

	assign out_free = !out_valid_q || !out_stall;
	assign advance  = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;
	assign in_take  = in_valid && !in_stall;

	assign index_ok       = {1'b0, index_s1} < (INDEX_W+1)'(NUM_LINES);
	assign line_bit       = LINE_MASK & (LINE_W'(1) << index_s1);
	assign size_over_word = size_s1 > SIZE_WORD;
	assign size_over_half = size_s1 > SIZE_HALF;

	always_comb begin
		pending_nxt = pending_q;
		enable_nxt  = enable_q;
		wait_nxt    = wait_q;
		master_nxt  = master_q;
		rdata_nxt   = '0;
		error_nxt   = 1'b0;
		case (action_s1)
			ACT_LINE: begin
				if (index_ok) begin
					if (level_s1)
						pending_nxt = pending_q | line_bit;
					else
						pending_nxt = pending_q & ~line_bit;
				end
			end
			ACT_READ: begin
				unique case (ofs_s1)
					OFS_ENABLE: begin
						error_nxt = size_over_word;
						if (size_s1 == SIZE_HALF)
							rdata_nxt = {{(DATA_W-LINE_W){1'b0}}, enable_q};
						else
							rdata_nxt = {pending_q, enable_q};
					end
					OFS_PENDING: begin
						error_nxt = size_over_half;
						rdata_nxt = {{(DATA_W-LINE_W){1'b0}}, pending_q};
					end
					OFS_WAIT: begin
						error_nxt = size_over_word;
						rdata_nxt = {{(DATA_W-WAIT_W){1'b0}}, wait_q};
					end
					OFS_MASTER: begin
						error_nxt = size_over_word;
						rdata_nxt = {{(DATA_W-1){1'b0}}, master_q};
					end
					default: begin
						error_nxt = 1'b1;
					end
				endcase
			end
			ACT_WRITE: begin
				unique case (ofs_s1)
					OFS_ENABLE: begin
						error_nxt  = size_over_word;
						enable_nxt = data_s1[LINE_W-1:0];
						if (size_s1 >= SIZE_WORD)
							pending_nxt = pending_q & ~data_s1[DATA_W-1:LINE_W];
					end
					OFS_PENDING: begin
						error_nxt   = size_over_half;
						pending_nxt = pending_q & ~data_s1[LINE_W-1:0];
					end
					OFS_WAIT: begin
						error_nxt = size_over_word;
						wait_nxt  = data_s1[WAIT_W-1:0];
					end
					OFS_MASTER: begin
						error_nxt  = size_over_word;
						master_nxt = data_s1[0];
					end
					default: begin
						error_nxt = 1'b1;
					end
				endcase
			end
			default: begin
			end
		endcase
		irq_nxt = master_nxt && |(pending_nxt & enable_nxt);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take || advance) begin
			valid_s1 <= in_take;
		end
	end

	// input register; hold while the result side is stalled
	always_ff @(posedge clk) begin
		if (in_take) begin
			action_s1 <= action;
			index_s1  <= line_index;
			level_s1  <= line_level;
			ofs_s1    <= reg_offset;
			size_s1   <= access_size;
			data_s1   <= write_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q   <= '0;
			enable_q    <= '0;
			wait_q      <= '0;
			master_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				pending_q <= pending_nxt;
				enable_q  <= enable_nxt;
				wait_q    <= wait_nxt;
				master_q  <= master_nxt;
			end
			if (out_free)
				out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			read_data_q <= rdata_nxt;
			irq_q       <= irq_nxt;
			error_q     <= error_nxt;
		end
	end

	assign out_valid    = out_valid_q;
	assign read_data    = read_data_q;
	assign irq_out      = irq_q;
	assign access_error = error_q;

	a_stall_needs_word: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1)
		else $error("input stalled with an empty input register");

	a_irq_matches_state: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (irq_q == (master_q && |(pending_q & enable_q))))
		else $error("held interrupt request disagrees with register state");

	a_pending_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(pending_q & ~LINE_MASK) == '0)
		else $error("pending flag set on an unimplemented line");

	a_state_held_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(pending_q) && $stable(enable_q) && $stable(master_q))
		else $error("register state changed without a word passing");

endmodule

[tb/tb_interrupt_controller_regs_core.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_interrupt_controller_regs_core
// Drives line events, register reads and register writes into the interrupt
// controller core and checks every result word against a cycle-free model of
// the register file: read data, interrupt request and access error. Starts
// with directed corner cases, then random traffic under several idling mixes
// and one long output hold that fills the core and stalls its input.
// ----------------------------------------------------------------------------
module tb_interrupt_controller_regs_core;
	import icr_pkg::*;

	localparam logic [ACTION_W-1:0] ACT_NONE = 2'd3;
	localparam int IDLE_LIMIT = 400;
	localparam int HOLD_CYCLES = 64;

	typedef struct packed {
		logic [ACTION_W-1:0] act;
		logic [INDEX_W-1:0]  idx;
		logic                lvl;
		logic [OFS_W-1:0]    ofs;
		logic [SIZE_W-1:0]   size;
		logic [DATA_W-1:0]   data;
	} bus_word_t;

	typedef struct packed {
		logic [DATA_W-1:0] rdata;
		logic              irq;
		logic              err;
	} result_t;

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_stall;
	logic [ACTION_W-1:0] action;
	logic [INDEX_W-1:0]  line_index;
	logic                line_level;
	logic [OFS_W-1:0]    reg_offset;
	logic [SIZE_W-1:0]   access_size;
	logic [DATA_W-1:0]   write_data;
	logic                out_valid;
	logic                out_stall;
	logic [DATA_W-1:0]   read_data;
	logic                irq_out;
	logic                access_error;

	logic [LINE_W-1:0] mdl_pending;
	logic [LINE_W-1:0] mdl_enable;
	logic [WAIT_W-1:0] mdl_wait;
	logic              mdl_master;

	result_t awaited_results[$];
	int      mismatch_count;
	int      idle_cycles;
	int      tx_gap_max;
	int      rx_stall_max;
	int      sink_hold;

	interrupt_controller_regs_core dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.action      (action),
		.line_index  (line_index),
		.line_level  (line_level),
		.reg_offset  (reg_offset),
		.access_size (access_size),
		.write_data  (write_data),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.read_data   (read_data),
		.irq_out     (irq_out),
		.access_error(access_error)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// apply one word to the register copy and return the result it gives
	function automatic result_t apply_to_regs(input bus_word_t w);
		result_t r;
		r = '0;
		case (w.act)
			ACT_LINE: begin
				if (int'(w.idx) < NUM_LINES) begin
					mdl_pending[w.idx] = w.lvl;
					mdl_pending = mdl_pending & LINE_MASK;
				end
			end
			ACT_READ: begin
				case (w.ofs)
					OFS_ENABLE: begin
						r.err = w.size > SIZE_WORD;
						r.rdata = (w.size == SIZE_HALF) ? DATA_W'(mdl_enable)
							: {mdl_pending, mdl_enable};
					end
					OFS_PENDING: begin
						r.err = w.size > SIZE_HALF;
						r.rdata = DATA_W'(mdl_pending);
					end
					OFS_WAIT: begin
						r.err = w.size > SIZE_WORD;
						r.rdata = DATA_W'(mdl_wait);
					end
					OFS_MASTER: begin
						r.err = w.size > SIZE_WORD;
						r.rdata = DATA_W'(mdl_master);
					end
					default: r.err = 1'b1;
				endcase
			end
			ACT_WRITE: begin
				case (w.ofs)
					OFS_ENABLE: begin
						r.err = w.size > SIZE_WORD;
						mdl_enable = w.data[15:0];
						if (w.size >= SIZE_WORD)
							mdl_pending = mdl_pending & ~w.data[31:16];
					end
					OFS_PENDING: begin
						r.err = w.size > SIZE_HALF;
						mdl_pending = mdl_pending & ~w.data[15:0];
					end
					OFS_WAIT: begin
						r.err = w.size > SIZE_WORD;
						mdl_wait = w.data[WAIT_W-1:0];
					end
					OFS_MASTER: begin
						r.err = w.size > SIZE_WORD;
						mdl_master = w.data[0];
					end
					default: r.err = 1'b1;
				endcase
			end
			default: ;
		endcase
		r.irq = mdl_master && ((mdl_pending & mdl_enable) != '0);
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [DATA_W-1:0] want,
			input logic [DATA_W-1:0] got);
		$display("%0t mismatch on %s: expected %h, got %h", $realtime, what, want, got);
		mismatch_count++;
	endtask

	// predict on every accepted input word, check every accepted result word
	always @(posedge clk) begin
		result_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (awaited_results.size() == 0) begin
					report_mismatch("unexpected result", '0, read_data);
				end else begin
					want = awaited_results.pop_front();
					if (read_data !== want.rdata)
						report_mismatch("read_data", want.rdata, read_data);
					if (irq_out !== want.irq)
						report_mismatch("irq_out", DATA_W'(want.irq), DATA_W'(irq_out));
					if (access_error !== want.err)
						report_mismatch("access_error", DATA_W'(want.err),
							DATA_W'(access_error));
				end
			end
			if (in_valid && !in_stall)
				awaited_results.push_back(apply_to_regs({action, line_index, line_level,
					reg_offset, access_size, write_data}));
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("tb_interrupt_controller_regs_core: FAIL");
				$finish;
			end
		end
	end

	// result sink: random stalls per word, or a long hold when asked
	initial begin
		int n;
		out_stall = 1'b0;
		forever begin
			if (sink_hold > 0) begin
				n = sink_hold;
				sink_hold = 0;
			end else begin
				n = rx_stall_max > 0 ? $urandom_range(0, rx_stall_max) : 0;
			end
			if (n > 0) begin
				out_stall <= 1'b1;
				repeat (n) @(negedge clk);
			end
			out_stall <= 1'b0;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
			@(negedge clk);
		end
	end

	task automatic send_word(input bus_word_t w);
		int gap;
		gap = tx_gap_max > 0 ? $urandom_range(0, tx_gap_max) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid    <= 1'b1;
		action      <= w.act;
		line_index  <= w.idx;
		line_level  <= w.lvl;
		reg_offset  <= w.ofs;
		access_size <= w.size;
		write_data  <= w.data;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		@(negedge clk);
	endtask

	// unused fields carry random values so they toggle too
	function automatic bus_word_t filler_word();
		bus_word_t w;
		w.act  = ACT_NONE;
		w.idx  = INDEX_W'($urandom);
		w.lvl  = 1'($urandom);
		w.ofs  = OFS_W'($urandom);
		w.size = SIZE_W'($urandom);
		w.data = $urandom;
		return w;
	endfunction

	task automatic line_event(input logic [INDEX_W-1:0] idx, input logic lvl);
		bus_word_t w;
		w = filler_word();
		w.act = ACT_LINE;
		w.idx = idx;
		w.lvl = lvl;
		send_word(w);
	endtask

	task automatic reg_read(input logic [OFS_W-1:0] ofs, input logic [SIZE_W-1:0] size);
		bus_word_t w;
		w = filler_word();
		w.act = ACT_READ;
		w.ofs = ofs;
		w.size = size;
		send_word(w);
	endtask

	task automatic reg_write(input logic [OFS_W-1:0] ofs, input logic [SIZE_W-1:0] size,
			input logic [DATA_W-1:0] data);
		bus_word_t w;
		w = filler_word();
		w.act = ACT_WRITE;
		w.ofs = ofs;
		w.size = size;
		w.data = data;
		send_word(w);
	endtask

	function automatic bus_word_t random_word();
		bus_word_t w;
		int pick;
		w = filler_word();
		pick = $urandom_range(0, 99);
		w.act = pick < 40 ? ACT_LINE : pick < 65 ? ACT_READ : pick < 95 ? ACT_WRITE : ACT_NONE;
		case ($urandom_range(0, 9))
			0, 1: w.ofs = OFS_ENABLE;
			2, 3: w.ofs = OFS_PENDING;
			4, 5: w.ofs = OFS_WAIT;
			6, 7: w.ofs = OFS_MASTER;
			default: ;
		endcase
		pick = $urandom_range(0, 9);
		if (pick < 3)
			w.size = SIZE_HALF;
		else if (pick < 6)
			w.size = SIZE_WORD;
		else if (pick < 7)
			w.size = 3'd1;
		return w;
	endfunction

	task automatic test_directed_cases();
		bus_word_t w;
		tx_gap_max = 3;
		rx_stall_max = 3;
		reg_read(OFS_ENABLE, SIZE_HALF);
		reg_read(OFS_ENABLE, SIZE_WORD);
		reg_read(OFS_PENDING, SIZE_HALF);
		reg_read(OFS_WAIT, SIZE_WORD);
		reg_read(OFS_MASTER, SIZE_WORD);
		line_event(4'd15, 1'b1);
		line_event(4'd0, 1'b1);
		reg_write(OFS_ENABLE, SIZE_HALF, 32'hffff_ffff);
		reg_write(OFS_MASTER, SIZE_WORD, 32'h0000_0001);
		reg_read(OFS_ENABLE, 3'd0);
		reg_read(OFS_ENABLE, 3'd7);
		reg_write(OFS_PENDING, 3'd3, 32'h0000_8000);
		reg_read(OFS_PENDING, 3'd1);
		reg_write(OFS_ENABLE, 3'd1, 32'hffff_0000);
		reg_write(OFS_ENABLE, 3'd5, 32'hffff_ffff);
		reg_write(OFS_WAIT, SIZE_WORD, 32'hffff_ffff);
		reg_read(OFS_WAIT, 3'd6);
		reg_read(8'hff, SIZE_WORD);
		reg_write(8'h01, SIZE_WORD, 32'hffff_ffff);
		w = '1;
		send_word(w);
		line_event(4'd7, 1'b1);
		line_event(4'd7, 1'b0);
		reg_write(OFS_MASTER, 3'd7, 32'hffff_fffe);
		reg_write(OFS_WAIT, 3'd1, 32'h0000_0000);
		reg_read(OFS_MASTER, 3'd1);
	endtask

	task automatic test_random_traffic(input int count, input int tx_max, input int rx_max);
		tx_gap_max = tx_max;
		rx_stall_max = rx_max;
		repeat (count) send_word(random_word());
	endtask

	// hold the output for a long stretch while words keep coming
	task automatic test_output_hold();
		tx_gap_max = 0;
		rx_stall_max = 0;
		sink_hold = HOLD_CYCLES;
		repeat (60) send_word(random_word());
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		action = ACT_LINE;
		line_index = '0;
		line_level = 1'b0;
		reg_offset = OFS_ENABLE;
		access_size = SIZE_WORD;
		write_data = '0;
		mdl_pending = '0;
		mdl_enable = '0;
		mdl_wait = '0;
		mdl_master = 1'b0;
		mismatch_count = 0;
		idle_cycles = 0;
		tx_gap_max = 0;
		rx_stall_max = 0;
		sink_hold = 0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_directed_cases();
		test_random_traffic(460, 3, 3);
		test_random_traffic(300, 0, 0);
		test_output_hold();
		test_random_traffic(300, 0, 3);
		test_random_traffic(300, 3, 0);

		in_valid <= 1'b0;
		while (awaited_results.size() != 0) @(posedge clk);
		repeat (6) @(posedge clk);
		if (mismatch_count == 0)
			$display("tb_interrupt_controller_regs_core: PASS");
		else
			$display("tb_interrupt_controller_regs_core: FAIL");
		$finish;
	end

endmodule
